// ----- rtl/core/cbor_item_skipper_core_assert.svh -----
// assertion macros for the cbor item skipper core
`ifndef CBOR_ITEM_SKIPPER_CORE_ASSERT_SVH
`define CBOR_ITEM_SKIPPER_CORE_ASSERT_SVH

// property that must hold at every clock edge outside reset
`define CSKP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// property whose consequent is checked in the cycle after the antecedent
`define CSKP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/cbor_skp_pkg.sv -----
// shared types and constants for the cbor item skipper
package cbor_skp_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int COUNT_W   = 33;
	localparam int ARG_W     = 32;
	localparam int NEST_W    = 5;

	// additional info codes for multi-byte arguments
	localparam logic [4:0] AI_ONE  = 5'd24;
	localparam logic [4:0] AI_FOUR = 5'd26;

	// major types with special handling
	localparam logic [2:0] MT_BSTR  = 3'd2;
	localparam logic [2:0] MT_TSTR  = 3'd3;
	localparam logic [2:0] MT_ARRAY = 3'd4;
	localparam logic [2:0] MT_MAP   = 3'd5;
	localparam logic [2:0] MT_TAG   = 3'd6;

	// error codes
	localparam logic [2:0] ERR_NONE    = 3'd0;
	localparam logic [2:0] ERR_ADDINFO = 3'd1;
	localparam logic [2:0] ERR_TAG     = 3'd2;
	localparam logic [2:0] ERR_TRUNC   = 3'd3;
	localparam logic [2:0] ERR_DEPTH   = 3'd4;

	typedef enum logic [1:0] {
		PH_HEAD,
		PH_ARG,
		PH_PAYLOAD,
		PH_IDLE
	} phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_beat_t;

	typedef struct packed {
		logic              head_valid;
		logic [2:0]        major_type;
		logic [ARG_W-1:0]  argument_value;
		logic [NEST_W-1:0] nest_level;
		logic              item_done;
		logic [2:0]        error_code;
	} out_beat_t;

	// stack commands and status
	typedef struct packed {
		logic push;
		logic cascade;
		logic clear;
	} stk_cmd_t;

	typedef struct packed {
		logic full;
		logic done;
	} stk_stat_t;

endpackage

// ----- rtl/core/cbor_item_skipper_core.sv -----
// cbor item skipper: walks one data item per buffer, one byte per beat
// a byte's result passes through the input register and then the result register
// throughput: one byte per cycle while the result side does not stall; the stack pop cascade is one priority encode
// over the open levels, resolved in the same cycle as the byte
// reset: control state and stack pointer clear; stack contents are left as is
module cbor_item_skipper_core import cbor_skp_pkg::*; #(
	parameter int MAX_DEPTH = DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      byte_valid,
	output logic      byte_stall,
	input  in_beat_t  byte_beat,
	output logic      rslt_valid,
	input  logic      rslt_stall,
	output out_beat_t rslt_beat
);

`include "cbor_item_skipper_core_assert.svh"

	localparam int TOP_W = $clog2(MAX_DEPTH + 1);

	logic       in_valid_s1;
	in_beat_t   in_beat_s1;

	phase_t           phase_q, phase_d;
	logic [2:0]       arg_left_q, arg_left_d;
	logic [ARG_W-1:0] arg_accum_q, accum_d;
	logic [2:0]       cur_major_q, major_d;
	logic [ARG_W-1:0] payload_left_q, payload_d;

	logic             rslt_valid_q;
	out_beat_t        rslt_beat_q;

	logic [7:0]       b;
	logic             last;
	logic [4:0]       add;
	logic             have_head, bad_ai, pay_end, start_arg;
	logic             to_payload, cascade, push, done, fin, trunc, emit, adv;
	logic [2:0]       err, err_o;
	out_beat_t        res;

	stk_cmd_t         stk_cmd;
	stk_stat_t        stk_stat;
	logic [TOP_W-1:0] stk_top;
	logic [COUNT_W-1:0] push_count;

	assign b    = in_beat_s1.data_byte;
	assign last = in_beat_s1.last_byte;
	assign add  = b[4:0];

	// handshake: advance a held byte when it gives no result or the result register can take one
	assign adv        = in_valid_s1 && (!emit || !rslt_valid_q || !rslt_stall);
	assign byte_stall = in_valid_s1 && !adv;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			in_valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!byte_stall && byte_valid) begin
			in_beat_s1 <= byte_beat;
		end
	end

	// head and argument decode
	always_comb begin
		accum_d   = arg_accum_q;
		arg_left_d = arg_left_q;
		major_d   = cur_major_q;
		payload_d = payload_left_q;
		have_head = 1'b0;
		bad_ai    = 1'b0;
		pay_end   = 1'b0;
		start_arg = 1'b0;
		unique case (phase_q)
			PH_HEAD: begin
				major_d = b[7:5];
				if (add < AI_ONE) begin
					accum_d   = ARG_W'(add);
					have_head = 1'b1;
				end else if (add <= AI_FOUR) begin
					arg_left_d = 3'b001 << add[1:0];
					accum_d    = '0;
					start_arg  = 1'b1;
				end else begin
					bad_ai = 1'b1;
				end
			end
			PH_ARG: begin
				accum_d    = {arg_accum_q[ARG_W-9:0], b};
				arg_left_d = arg_left_q - 3'd1;
				have_head  = (arg_left_q == 3'd1);
			end
			PH_PAYLOAD: begin
				payload_d = payload_left_q - ARG_W'(1);
				pay_end   = (payload_left_q == ARG_W'(1));
			end
			PH_IDLE: begin
			end
			default: begin
			end
		endcase
	end

	// action on a complete head or payload end
	always_comb begin
		cascade    = pay_end;
		push       = 1'b0;
		to_payload = 1'b0;
		err        = bad_ai ? ERR_ADDINFO : ERR_NONE;
		if (have_head) begin
			case (major_d) inside
				MT_BSTR, MT_TSTR: begin
					if (accum_d == '0) begin
						cascade = 1'b1;
					end else begin
						to_payload = 1'b1;
					end
				end
				MT_ARRAY, MT_MAP: begin
					if (accum_d == '0) begin
						cascade = 1'b1;
					end else if (stk_stat.full) begin
						err = ERR_DEPTH;
					end else begin
						push = 1'b1;
					end
				end
				MT_TAG: begin
					err = ERR_TAG;
				end
				default: begin
					cascade = 1'b1;
				end
			endcase
		end
		done  = cascade && stk_stat.done;
		fin   = (err != ERR_NONE) || done;
		trunc = !fin && last && (phase_q != PH_IDLE);
		err_o = trunc ? ERR_TRUNC : err;
		emit  = (phase_q != PH_IDLE) && (have_head || bad_ai || done || trunc);
	end

	assign push_count = (major_d == MT_MAP) ? {accum_d, 1'b0} : {1'b0, accum_d};

	// next phase
	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			PH_HEAD: begin
				if (start_arg) begin
					phase_d = PH_ARG;
				end
			end
			PH_ARG: begin
			end
			PH_PAYLOAD: begin
				if (pay_end) begin
					phase_d = PH_HEAD;
				end
			end
			PH_IDLE: begin
			end
			default: begin
			end
		endcase
		if (have_head) begin
			phase_d = to_payload ? PH_PAYLOAD : PH_HEAD;
		end
		if (fin) begin
			phase_d = PH_IDLE;
		end
		if (last) begin
			phase_d = PH_HEAD;
		end
	end

	// result beat
	always_comb begin
		res.head_valid     = have_head;
		res.major_type     = have_head ? major_d : 3'd0;
		res.argument_value = have_head ? accum_d : '0;
		res.nest_level     = NEST_W'(stk_top);
		res.item_done      = done;
		res.error_code     = err_o;
	end

	// walker state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_HEAD;
			arg_left_q     <= '0;
			arg_accum_q    <= '0;
			cur_major_q    <= '0;
			payload_left_q <= '0;
		end else if (adv) begin
			phase_q <= phase_d;
			if (last) begin
				arg_left_q     <= '0;
				arg_accum_q    <= '0;
				cur_major_q    <= '0;
				payload_left_q <= '0;
			end else begin
				arg_left_q     <= arg_left_d;
				arg_accum_q    <= accum_d;
				cur_major_q    <= major_d;
				payload_left_q <= to_payload ? accum_d : payload_d;
			end
		end
	end

	// container stack
	assign stk_cmd.push    = adv && push;
	assign stk_cmd.cascade = adv && cascade;
	assign stk_cmd.clear   = adv && last;

	cbor_skp_stack #(
		.MAX_DEPTH(MAX_DEPTH)
	) u_stack (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (stk_cmd),
		.push_count(push_count),
		.top       (stk_top),
		.stat      (stk_stat)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rslt_valid_q <= 1'b0;
		end else if (adv && emit) begin
			rslt_valid_q <= 1'b1;
		end else if (!rslt_stall) begin
			rslt_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			rslt_beat_q <= res;
		end
	end

	assign rslt_valid = rslt_valid_q;
	assign rslt_beat  = rslt_beat_q;

	// checks
	`CSKP_ASSERT(a_done_no_err, !(rslt_valid && rslt_beat.item_done && (rslt_beat.error_code != ERR_NONE)), "done beat carries an error")
	`CSKP_ASSERT(a_nohead_zero, !(rslt_valid && !rslt_beat.head_valid && ((rslt_beat.major_type != 3'd0) || (rslt_beat.argument_value != '0))), "head fields set without a head")
	`CSKP_ASSERT_NEXT(a_last_resets, adv && last, (phase_q == PH_HEAD) && (stk_top == '0), "state not cleared after last byte")
	`CSKP_ASSERT(a_top_bound, stk_top <= TOP_W'(MAX_DEPTH), "stack pointer beyond depth")

endmodule

// ----- rtl/core/cbor_skp_stack.sv -----
// container count stack with a combinational pop cascade
module cbor_skp_stack import cbor_skp_pkg::*; #(
	parameter int MAX_DEPTH = DEPTH_DEF,
	localparam int TW = $clog2(MAX_DEPTH + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  stk_cmd_t           cmd,
	input  logic [COUNT_W-1:0] push_count,
	output logic [TW-1:0]      top,
	output stk_stat_t          stat
);

	logic [COUNT_W-1:0] counts_q [MAX_DEPTH];
	logic [TW-1:0]      top_q;
	logic [MAX_DEPTH-1:0] dec_sel;
	logic [TW-1:0]      casc_top;

	// find the highest open level that does not finish with this element
	always_comb begin
		dec_sel  = '0;
		casc_top = '0;
		for (int j = 0; j < MAX_DEPTH; j++) begin
			if ((TW'(j) < top_q) && (counts_q[j] != COUNT_W'(1))) begin
				dec_sel    = '0;
				dec_sel[j] = 1'b1;
				casc_top   = TW'(j + 1);
			end
		end
	end

	assign stat.done = ~(|dec_sel);
	assign stat.full = (top_q == TW'(MAX_DEPTH));
	assign top       = top_q;

	// stack pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q <= '0;
		end else if (cmd.clear) begin
			top_q <= '0;
		end else if (cmd.push) begin
			top_q <= top_q + TW'(1);
		end else if (cmd.cascade) begin
			top_q <= casc_top;
		end
	end

	// per-level counts, each updated in place
	always_ff @(posedge clk) begin
		for (int j = 0; j < MAX_DEPTH; j++) begin
			if (cmd.push && (TW'(j) == top_q)) begin
				counts_q[j] <= push_count;
			end else if (cmd.cascade && dec_sel[j]) begin
				counts_q[j] <= counts_q[j] - COUNT_W'(1);
			end
		end
	end

endmodule

// ----- test/cbor_item_skipper_core_check.sv -----
// result checker for the cbor item skipper: predicts each result beat and compares it
`timescale 1ns / 100ps

module cbor_item_skipper_core_check import cbor_skp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      byte_valid,
	input  logic      byte_stall,
	input  in_beat_t  byte_beat,
	input  logic      rslt_valid,
	input  logic      rslt_stall,
	input  out_beat_t rslt_beat,
	output int        mismatches,
	output int        waiting,
	output int        checked,
	output int        done_seen,
	output int        errors_seen
);

	// walker state, kept apart from the block
	phase_t            w_phase;
	logic [2:0]        w_arg_left;
	logic [ARG_W-1:0]  w_accum;
	logic [2:0]        w_major;
	logic [ARG_W-1:0]  w_payload;
	logic [COUNT_W-1:0] w_counts [DEPTH_DEF];
	int                w_top;

	// result beats predicted but not yet seen
	out_beat_t walk_results_q[$];

	function automatic void clear_walk();
		w_phase    = PH_HEAD;
		w_arg_left = '0;
		w_accum    = '0;
		w_major    = '0;
		w_payload  = '0;
		w_top      = 0;
		for (int i = 0; i < DEPTH_DEF; i++) w_counts[i] = '0;
	endfunction

	// one element finished: count down the open containers, popping finished ones
	function automatic bit close_element();
		logic [COUNT_W-1:0] c;
		while (w_top > 0) begin
			c = w_counts[w_top - 1] - 1'b1;
			w_counts[w_top - 1] = c;
			if (c != '0) return 1'b0;
			w_top--;
		end
		return 1'b1;
	endfunction

	// act on a decoded head; returns its error code
	function automatic logic [2:0] apply_head(logic [2:0] mt, logic [ARG_W-1:0] val,
			output bit fin);
		fin = 1'b0;
		case (mt)
			MT_BSTR, MT_TSTR: begin
				if (val == '0) begin
					fin = close_element();
				end else begin
					w_payload = val;
					w_phase   = PH_PAYLOAD;
				end
			end
			MT_ARRAY, MT_MAP: begin
				if (val == '0) begin
					fin = close_element();
				end else if (w_top >= DEPTH_DEF) begin
					return ERR_DEPTH;
				end else begin
					// a map holds two elements per entry
					w_counts[w_top] = (mt == MT_MAP) ? {val, 1'b0} : {1'b0, val};
					w_top++;
					w_phase = PH_HEAD;
				end
			end
			MT_TAG: begin
				return ERR_TAG;
			end
			default: begin
				fin = close_element();
			end
		endcase
		return ERR_NONE;
	endfunction

	// advance the walk by one byte; returns 1 when the byte gives a result beat
	function automatic bit walk_byte(input in_beat_t ib, output out_beat_t ob);
		logic [4:0]       ai;
		logic [2:0]       mj;
		logic [2:0]       err;
		logic [ARG_W-1:0] arg;
		bit               emit, hv, fin, have;
		int               lvl;
		emit = 1'b0;
		hv   = 1'b0;
		fin  = 1'b0;
		have = 1'b0;
		mj   = '0;
		err  = ERR_NONE;
		arg  = '0;
		lvl  = w_top;
		ob   = '0;
		// after done or error everything up to the last byte is dropped
		if (w_phase == PH_IDLE) begin
			if (ib.last_byte) clear_walk();
			return 1'b0;
		end
		case (w_phase)
			PH_HEAD: begin
				ai      = ib.data_byte[4:0];
				w_major = ib.data_byte[7:5];
				if (ai < AI_ONE) begin
					w_accum = {27'd0, ai};
					have    = 1'b1;
				end else if (ai <= AI_FOUR) begin
					w_arg_left = 3'd1 << (ai - AI_ONE);
					w_accum    = '0;
					w_phase    = PH_ARG;
				end else begin
					err  = ERR_ADDINFO;
					emit = 1'b1;
				end
			end
			PH_ARG: begin
				w_accum    = {w_accum[ARG_W-9:0], ib.data_byte};
				w_arg_left = w_arg_left - 3'd1;
				if (w_arg_left == '0) have = 1'b1;
			end
			default: begin
				// string payload is skipped
				w_payload = w_payload - 1'b1;
				if (w_payload == '0) begin
					w_phase = PH_HEAD;
					fin     = close_element();
					if (fin) emit = 1'b1;
				end
			end
		endcase
		if (have) begin
			hv      = 1'b1;
			emit    = 1'b1;
			mj      = w_major;
			arg     = w_accum;
			w_phase = PH_HEAD;
			err     = apply_head(w_major, w_accum, fin);
		end
		if (err != ERR_NONE || fin) begin
			w_phase = PH_IDLE;
		end else if (ib.last_byte) begin
			err  = ERR_TRUNC;
			emit = 1'b1;
		end
		if (ib.last_byte) clear_walk();
		ob.head_valid     = hv;
		ob.major_type     = mj;
		ob.argument_value = arg;
		ob.nest_level     = lvl[NEST_W-1:0];
		ob.item_done      = fin;
		ob.error_code     = err;
		return emit;
	endfunction

	function automatic void check_field(string fname, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch: expected %0h, got %0h", $time, fname, want, got);
			mismatches++;
		end
	endfunction

	// compare result beats first, then predict from the byte beat of this edge
	always @(posedge clk or negedge arst_n) begin : watch
		out_beat_t nb;
		out_beat_t want;
		if (!arst_n) begin
			clear_walk();
			walk_results_q.delete();
			mismatches  = 0;
			checked     = 0;
			done_seen   = 0;
			errors_seen = 0;
		end else begin
			if (rslt_valid && !rslt_stall) begin
				if (walk_results_q.size() == 0) begin
					$display("%0t: result beat with none outstanding: expected none, got %h",
						$time, rslt_beat);
					mismatches++;
				end else begin
					want = walk_results_q.pop_front();
					check_field("head_valid", want.head_valid, rslt_beat.head_valid);
					check_field("major_type", want.major_type, rslt_beat.major_type);
					check_field("argument_value", want.argument_value,
						rslt_beat.argument_value);
					check_field("nest_level", want.nest_level, rslt_beat.nest_level);
					check_field("item_done", want.item_done, rslt_beat.item_done);
					check_field("error_code", want.error_code, rslt_beat.error_code);
					checked++;
					if (want.item_done) done_seen++;
					if (want.error_code != ERR_NONE) errors_seen++;
				end
			end
			if (byte_valid && !byte_stall) begin
				if (walk_byte(byte_beat, nb)) walk_results_q.push_back(nb);
			end
		end
		waiting = walk_results_q.size();
	end

endmodule

// ----- test/cbor_item_skipper_core_test.sv -----
// testbench top for the cbor item skipper: byte stimulus, result stalls and verdict
`timescale 1ns / 100ps

module cbor_item_skipper_core_test;
	import cbor_skp_pkg::*;

	localparam logic [2:0] MT_UINT   = 3'd0;
	localparam logic [2:0] MT_NINT   = 3'd1;
	localparam logic [2:0] MT_SIMPLE = 3'd7;
	localparam logic [4:0] AI_TWO    = AI_ONE + 5'd1;

	localparam int HOLD_CYCLES   = 400;
	localparam int IDLE_LIMIT    = 4000;
	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_BYTES  = 1150;

	typedef enum int {F_IMM, F_ONE, F_TWO, F_FOUR} arg_form_t;

	logic      clk;
	logic      arst_n;
	logic      byte_valid;
	logic      byte_stall;
	in_beat_t  byte_beat;
	logic      rslt_valid;
	logic      rslt_stall;
	out_beat_t rslt_beat;
	logic      hold_req;

	int mismatches;
	int waiting;
	int checked;
	int done_seen;
	int errors_seen;

	int         quiet;
	int         bytes_sent;
	int         buffers;
	int         fed;
	bit         steady_feed;
	logic [7:0] buf_q[$];

	cbor_item_skipper_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_beat  (byte_beat),
		.rslt_valid (rslt_valid),
		.rslt_stall (rslt_stall),
		.rslt_beat  (rslt_beat)
	);

	cbor_item_skipper_core_check walk_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_valid  (byte_valid),
		.byte_stall  (byte_stall),
		.byte_beat   (byte_beat),
		.rslt_valid  (rslt_valid),
		.rslt_stall  (rslt_stall),
		.rslt_beat   (rslt_beat),
		.mismatches  (mismatches),
		.waiting     (waiting),
		.checked     (checked),
		.done_seen   (done_seen),
		.errors_seen (errors_seen)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// head with an explicit argument width
	function automatic void put_head_form(logic [2:0] mt, logic [31:0] val, arg_form_t form);
		case (form)
			F_IMM: begin
				buf_q.push_back({mt, val[4:0]});
			end
			F_ONE: begin
				buf_q.push_back({mt, AI_ONE});
				buf_q.push_back(val[7:0]);
			end
			F_TWO: begin
				buf_q.push_back({mt, AI_TWO});
				buf_q.push_back(val[15:8]);
				buf_q.push_back(val[7:0]);
			end
			default: begin
				buf_q.push_back({mt, AI_FOUR});
				buf_q.push_back(val[31:24]);
				buf_q.push_back(val[23:16]);
				buf_q.push_back(val[15:8]);
				buf_q.push_back(val[7:0]);
			end
		endcase
	endfunction

	// shortest form mostly, now and then a wider one
	function automatic void put_head(logic [2:0] mt, logic [31:0] val);
		arg_form_t form;
		if (val < AI_ONE) form = F_IMM;
		else if (val[31:8] == '0) form = F_ONE;
		else if (val[31:16] == '0) form = F_TWO;
		else form = F_FOUR;
		if ($urandom_range(0, 3) == 0) form = arg_form_t'($urandom_range(int'(form), 3));
		put_head_form(mt, val, form);
	endfunction

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 5))
			0: return $urandom_range(0, 23);
			1: return $urandom_range(24, 255);
			2: return $urandom_range(256, 65535);
			3: return $urandom;
			4: return 32'hFFFF_FFFF;
			default: return '0;
		endcase
	endfunction

	function automatic void put_noise(int lo, int hi);
		repeat ($urandom_range(lo, hi)) buf_q.push_back(8'($urandom));
	endfunction

	// one well-formed item with random content, built level by level
	function automatic void put_item(int max_nest, int max_elems);
		int open_left[$];
		int nelem;
		int k;
		int n;
		logic [2:0] mt;
		open_left.push_back(1);
		nelem = 0;
		while (open_left.size() > 0) begin
			open_left[$] = open_left[$] - 1;
			nelem++;
			k = $urandom_range(0, 9);
			if (k < 3 && open_left.size() <= max_nest && nelem < max_elems) begin
				mt = (k == 0) ? MT_MAP : MT_ARRAY;
				n  = $urandom_range(0, 3);
				put_head(mt, n);
				if (n > 0) open_left.push_back((mt == MT_MAP) ? 2 * n : n);
			end else if (k < 6) begin
				n = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 40) : $urandom_range(0, 5);
				put_head((k == 3) ? MT_BSTR : MT_TSTR, n);
				put_noise(n, n);
			end else begin
				mt = (k == 6) ? MT_UINT : (k == 7) ? MT_NINT : MT_SIMPLE;
				put_head(mt, pick_value());
			end
			while (open_left.size() > 0 && open_left[$] == 0) void'(open_left.pop_back());
		end
	endfunction

	function automatic int pick_gap();
		int r;
		if (steady_feed) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// one byte beat; valid only drops during a gap before it
	task automatic send_byte(input logic [7:0] b, input logic lst);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			byte_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_valid <= 1'b1;
		byte_beat  <= '{data_byte: b, last_byte: lst};
		@(posedge clk);
		while (byte_stall) @(posedge clk);
		bytes_sent++;
	endtask

	task automatic send_buffer();
		int n;
		n = buf_q.size();
		for (int i = 0; i < n; i++) send_byte(buf_q[i], i == n - 1);
		buf_q.delete();
		buffers++;
	endtask

	// sender pauses until every predicted result beat has come back
	task automatic drain();
		byte_valid <= 1'b0;
		do @(negedge clk); while (waiting != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// result side: random stall runs, one long hold on request
	initial begin : result_sink
		int  hold_left;
		int  run_left;
		bit  stalling;
		bit  hold_taken;
		hold_left  = 0;
		run_left   = 0;
		stalling   = 1'b0;
		hold_taken = 1'b0;
		rslt_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_taken) begin
				hold_taken = 1'b1;
				hold_left  = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				stalling = 1'b1;
			end else begin
				if (run_left == 0) begin
					stalling = !stalling;
					if (stalling)
						run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
							: $urandom_range(1, 3);
					else
						run_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
							: $urandom_range(1, 12);
				end
				run_left--;
			end
			rslt_stall <= stalling;
		end
	end

	// no beat on either side for too long ends the run
	always @(posedge clk) begin
		if (!arst_n || (byte_valid && !byte_stall) || (rslt_valid && !rslt_stall))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= IDLE_LIMIT) begin
			$display("%0t: no beat for %0d cycles", $time, IDLE_LIMIT);
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin : stimulus
		int  kind;
		int  cut;
		bit  paused;
		arst_n      <= 1'b0;
		byte_valid  <= 1'b0;
		byte_beat   <= '0;
		hold_req    <= 1'b0;
		steady_feed = 1'b0;
		paused      = 1'b0;
		bytes_sent  = 0;
		buffers     = 0;
		fed         = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// argument extremes and the scalar types
		put_head_form(MT_UINT, 32'd0, F_IMM);
		send_buffer();
		put_head_form(MT_UINT, 32'hFFFF_FFFF, F_FOUR);
		send_buffer();
		put_head_form(MT_NINT, 32'h0000_00FF, F_ONE);
		send_buffer();
		put_head_form(MT_SIMPLE, 32'h0000_FFFF, F_TWO);
		send_buffer();

		// empty strings and containers finish at once
		put_head_form(MT_BSTR, 32'd0, F_IMM);
		send_buffer();
		put_head_form(MT_TSTR, 32'd0, F_ONE);
		send_buffer();
		put_head_form(MT_ARRAY, 32'd0, F_TWO);
		send_buffer();
		put_head_form(MT_MAP, 32'd0, F_FOUR);
		send_buffer();

		// short text, then a one-entry map
		put_head_form(MT_TSTR, 32'd2, F_IMM);
		put_noise(2, 2);
		send_buffer();
		put_head_form(MT_MAP, 32'd1, F_IMM);
		put_head_form(MT_UINT, 32'd1, F_IMM);
		put_head_form(MT_BSTR, 32'd1, F_IMM);
		put_noise(1, 1);
		send_buffer();

		// each additional info value above 26, which the block rejects, with ignored bytes behind it
		for (int k = 1; k <= 5; k++) begin
			buf_q.push_back({3'(k + 2), AI_FOUR + 5'(k)});
			put_noise(1, 2);
			send_buffer();
		end

		// tag head, then a byte that is ignored
		put_head_form(MT_TAG, 32'd0, F_IMM);
		put_head_form(MT_UINT, 32'd0, F_IMM);
		send_buffer();

		// truncation: open array, inside an argument, head on the last byte, in a payload
		put_head_form(MT_ARRAY, 32'd2, F_IMM);
		put_head_form(MT_UINT, 32'd1, F_IMM);
		send_buffer();
		put_head_form(MT_UINT, 32'h0000_1234, F_TWO);
		void'(buf_q.pop_back());
		send_buffer();
		put_head_form(MT_ARRAY, 32'd1, F_IMM);
		send_buffer();
		put_head_form(MT_BSTR, 32'd3, F_IMM);
		put_noise(1, 1);
		send_buffer();

		// largest container counts, cut short
		put_head_form(MT_ARRAY, 32'hFFFF_FFFF, F_FOUR);
		send_buffer();
		put_head_form(MT_MAP, 32'hFFFF_FFFF, F_FOUR);
		put_head_form(MT_UINT, 32'd0, F_IMM);
		send_buffer();

		// full stack: cascade to done, one push too many, empty container on top
		repeat (DEPTH_DEF) put_head_form(MT_ARRAY, 32'd1, F_IMM);
		put_head_form(MT_UINT, 32'd0, F_IMM);
		send_buffer();
		repeat (DEPTH_DEF) put_head_form(MT_ARRAY, 32'd1, F_IMM);
		put_head_form(MT_ARRAY, 32'd1, F_IMM);
		put_noise(1, 2);
		send_buffer();
		repeat (DEPTH_DEF) put_head_form(MT_ARRAY, 32'd1, F_ONE);
		put_head_form(MT_MAP, 32'd0, F_IMM);
		send_buffer();

		// bytes after a finished item are dropped
		put_head_form(MT_UINT, 32'd0, F_IMM);
		put_head_form(MT_ARRAY, 32'd3, F_IMM);
		put_noise(1, 1);
		send_buffer();
		drain();

		// long result hold while bytes keep coming, so the block backs up
		hold_req    <= 1'b1;
		steady_feed = 1'b1;
		repeat (15) begin
			put_item(2, 4);
			send_buffer();
		end
		steady_feed = 1'b0;
		drain();

		// random buffers, mostly well-formed
		while (fed < RANDOM_BYTES) begin
			steady_feed = ($urandom_range(0, 6) == 0);
			kind = $urandom_range(0, 99);
			if (kind < 55) begin
				put_item(($urandom_range(0, 9) == 0) ? $urandom_range(4, 17)
					: $urandom_range(0, 3), $urandom_range(1, 12));
				fed += buf_q.size();
				if ($urandom_range(0, 3) == 0) put_noise(1, 3);
			end else if (kind < 70) begin
				put_item($urandom_range(0, 4), $urandom_range(2, 12));
				if (buf_q.size() > 1) begin
					cut = $urandom_range(1, buf_q.size() - 1);
					repeat (cut) void'(buf_q.pop_back());
				end
				fed += buf_q.size();
			end else if (kind < 80) begin
				put_head(MT_ARRAY, $urandom_range(2, 4));
				repeat ($urandom_range(0, 1)) put_item(1, 4);
				if ($urandom_range(0, 1))
					buf_q.push_back({3'($urandom_range(0, 7)), AI_FOUR + 5'($urandom_range(1, 5))});
				else
					put_head(MT_TAG, pick_value());
				fed += buf_q.size();
				put_noise(0, 3);
			end else if (kind < 86) begin
				repeat ($urandom_range(DEPTH_DEF - 2, DEPTH_DEF + 1))
					put_head($urandom_range(0, 1) ? MT_ARRAY : MT_MAP, 32'd1);
				put_item(1, 4);
				fed += buf_q.size();
			end else if (kind < 93) begin
				put_noise(1, 12);
				fed += buf_q.size();
			end else begin
				cut = $urandom_range(24, 300);
				put_head($urandom_range(0, 1) ? MT_BSTR : MT_TSTR, cut);
				put_noise(cut, cut);
				if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 20)) void'(buf_q.pop_back());
				fed += buf_q.size();
			end
			send_buffer();
			// one pause mid-run with everything returned
			if (!paused && fed >= RANDOM_BYTES / 2) begin
				paused = 1'b1;
				drain();
			end
		end
		steady_feed = 1'b0;
		drain();

		$display("covered %0d buffers, %0d bytes; %0d result beats compared", buffers,
			bytes_sent, checked);
		$display("of which %0d finished items and %0d error results", done_seen, errors_seen);
		if (mismatches == 0 && waiting == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ----- cbor_item_skipper_core.f -----
+incdir+rtl/core
rtl/core/cbor_skp_pkg.sv
rtl/core/cbor_skp_stack.sv
rtl/core/cbor_item_skipper_core.sv
test/cbor_item_skipper_core_check.sv
test/cbor_item_skipper_core_test.sv
